// ----- rtl/core/sfnp_pkg.sv -----
// Shared types, constants and helper functions of the swing foot next position core.
// No dependencies; every other file of the core imports this package.
package sfnp_pkg;

   // Register indexes on the configuration port (byte address = 8 * index).
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_SWING_TICKS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_TICKS = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LIFT_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STANCE_LEG0 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STANCE_LEG1 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_STANCE_LEG2 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_STANCE_LEG3 = 3'd7;

   localparam int STANCE_W = 48;
   localparam int LEG_W    = 2;

   // Angle path: Q.28 radians.
   localparam int ANG_W     = 43;
   localparam int MAG_W     = 43;
   localparam int RED_STEPS = 13;
   localparam int PH_W      = 32;
   localparam int VEC_W     = 32;
   localparam logic [MAG_W-1:0] TWO_PI_MAG = 43'd1686629713;
   localparam logic signed [PH_W-1:0] ANG_TWO_PI  = 32'sd1686629713;
   localparam logic signed [PH_W-1:0] ANG_PI      = 32'sd843314857;
   localparam logic signed [PH_W-1:0] ANG_HALF_PI = 32'sd421657428;
   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   // Placement and step path widths.
   localparam int PT_W  = 45;
   localparam int OFF_W = 27;
   localparam int TD_W  = 28;
   localparam int DEN_W = 26;
   localparam int NUM_W = 44;
   localparam int QUO_W = 18;
   localparam logic signed [PT_W-1:0] MIN_TIME = 45'sd4295;

   typedef struct packed {
      logic signed [15:0]      fx;
      logic signed [15:0]      fy;
      logic signed [15:0]      sx;
      logic signed [15:0]      sy;
      logic signed [15:0]      sz;
      logic signed [OFF_W-1:0] offx;
      logic signed [OFF_W-1:0] offy;
      logic                    notime;
      logic [15:0]             h;
      logic [DEN_W-1:0]        den;
   } sfnp_rot_side_type;

   typedef struct packed {
      logic signed [15:0]     fx;
      logic signed [15:0]     fy;
      logic signed [15:0]     sz;
      logic signed [TD_W-1:0] tdx;
      logic signed [TD_W-1:0] tdy;
      logic                   notime;
      logic [15:0]            h;
      logic                   neg_x;
      logic                   neg_y;
   } sfnp_div_side_type;

   function automatic logic signed [PH_W-1:0] atan_q28(input int unsigned idx);
      logic signed [PH_W-1:0] a;
      case (idx)
         0:  a = 32'sd210828714;
         1:  a = 32'sd124459457;
         2:  a = 32'sd65760959;
         3:  a = 32'sd33381290;
         4:  a = 32'sd16755422;
         5:  a = 32'sd8385879;
         6:  a = 32'sd4193963;
         7:  a = 32'sd2097109;
         8:  a = 32'sd1048571;
         9:  a = 32'sd524287;
         10: a = 32'sd262144;
         11: a = 32'sd131072;
         12: a = 32'sd65536;
         13: a = 32'sd32768;
         14: a = 32'sd16384;
         15: a = 32'sd8192;
         16: a = 32'sd4096;
         17: a = 32'sd2048;
         18: a = 32'sd1024;
         19: a = 32'sd512;
         20: a = 32'sd256;
         21: a = 32'sd128;
         22: a = 32'sd64;
         23: a = 32'sd32;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [TD_W-1:0] v);
      logic signed [15:0] r;
      if (v > 28'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -28'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/swing_foot_next_position_core.sv -----
// Swing foot next position: touchdown placement, XY approach step and lift profile.
// Throughput is one beat per cycle; every stage holds under stall, so a stalled result
// backs the pipeline up stage by stage rather than dropping or repeating anything.
// Synchronous reset empties the pipeline and returns the configuration registers to defaults.
module swing_foot_next_position_core #(
   parameter int NUM_LEGS     = 4,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // Input beats
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [16:0]        req_swing_progress,
   input  logic [1:0]         req_leg_number,
   input  logic signed [15:0] req_foot_x,
   input  logic signed [15:0] req_foot_y,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_yaw_rate,
   // Result beats
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_next_x,
   output logic signed [15:0] rsp_next_y,
   output logic signed [15:0] rsp_next_z,
   // Configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);
   import sfnp_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers. Each register sits on an 8-byte boundary,
   // so the register index is the upper address bits.
   // ------------------------------------------------------------------
   logic [9:0]          swing_ff;
   logic [9:0]          phase_ff;
   logic [15:0]         tick_ff;
   logic [14:0]         lift_ff;
   logic [STANCE_W-1:0] stance_ff [NUM_LEGS];
   logic                cfg_wr;
   logic [REG_IDX_W-1:0] cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         swing_ff <= 10'd10;
         phase_ff <= 10'd20;
         tick_ff  <= 16'd655;
         lift_ff  <= 15'd410;
         for (int l = 0; l < NUM_LEGS; l++) begin
            stance_ff[l] <= '0;
         end
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_SWING_TICKS: swing_ff <= pwdata[9:0];
            REG_PHASE_TICKS: phase_ff <= pwdata[9:0];
            REG_TICK_PERIOD: tick_ff  <= pwdata[15:0];
            REG_LIFT_HEIGHT: lift_ff  <= pwdata[14:0];
            REG_STANCE_LEG0, REG_STANCE_LEG1, REG_STANCE_LEG2, REG_STANCE_LEG3: begin
               for (int l = 0; l < NUM_LEGS; l++) begin
                  if (cfg_idx == REG_STANCE_LEG0 + REG_IDX_W'(l)) begin
                     stance_ff[l] <= pwdata[STANCE_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (cfg_idx)
         REG_SWING_TICKS: prdata = 64'(swing_ff);
         REG_PHASE_TICKS: prdata = 64'(phase_ff);
         REG_TICK_PERIOD: prdata = 64'(tick_ff);
         REG_LIFT_HEIGHT: prdata = 64'(lift_ff);
         REG_STANCE_LEG0, REG_STANCE_LEG1, REG_STANCE_LEG2, REG_STANCE_LEG3: begin
            for (int l = 0; l < NUM_LEGS; l++) begin
               if (cfg_idx == REG_STANCE_LEG0 + REG_IDX_W'(l)) begin
                  prdata = 64'(stance_ff[l]);
               end
            end
         end
         default: prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Front stages. Each stage loads when it is empty or when the stage
   // after it moves, so bubbles collapse and a full beat never waits
   // for an empty one ahead of it.
   // ------------------------------------------------------------------
   logic [2:0] f_v_ff;
   logic [3:0] f_rdy;
   logic       rot_in_stall;

   assign f_rdy[3]  = !rot_in_stall;
   assign f_rdy[2]  = !f_v_ff[2] || f_rdy[3];
   assign f_rdy[1]  = !f_v_ff[1] || f_rdy[2];
   assign f_rdy[0]  = !f_v_ff[0] || f_rdy[1];
   assign req_stall = !f_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= '0;
      end else begin
         if (f_rdy[0]) f_v_ff[0] <= req_valid;
         if (f_rdy[1]) f_v_ff[1] <= f_v_ff[0];
         if (f_rdy[2]) f_v_ff[2] <= f_v_ff[1];
      end
   end

   // Stage 0: stance lookup, swing time base and velocity times phase length.
   logic [STANCE_W-1:0] sel_stance;
   logic [25:0]         stp_in;
   logic signed [25:0]  vptx_in, vpty_in;
   logic signed [17:0]  remain_in;
   logic [16:0]         ph_in;

   always_comb begin
      sel_stance = '0;
      for (int l = 0; l < NUM_LEGS; l++) begin
         if (req_leg_number == LEG_W'(l)) begin
            sel_stance = stance_ff[l];
         end
      end
   end

   assign stp_in    = swing_ff * tick_ff;
   assign vptx_in   = req_vel_x * $signed({1'b0, phase_ff});
   assign vpty_in   = req_vel_y * $signed({1'b0, phase_ff});
   assign remain_in = 18'sd65536 - $signed({1'b0, req_swing_progress});
   // The lift triangle rises on progress in the first half and on the time left after.
   assign ph_in     = (req_swing_progress < 17'd32768) ? req_swing_progress : remain_in[16:0];

   logic [25:0]        stp_ff;
   logic signed [25:0] vptx_ff, vpty_ff;
   logic signed [17:0] remain_ff;
   logic [16:0]        ph_ff;
   logic signed [15:0] yaw0_ff, fx0_ff, fy0_ff, sx0_ff, sy0_ff, sz0_ff;

   always_ff @(posedge clock) begin
      if (f_rdy[0]) begin
         stp_ff    <= stp_in;
         vptx_ff   <= vptx_in;
         vpty_ff   <= vpty_in;
         remain_ff <= remain_in;
         ph_ff     <= ph_in;
         yaw0_ff   <= req_yaw_rate;
         fx0_ff    <= req_foot_x;
         fy0_ff    <= req_foot_y;
         sx0_ff    <= sel_stance[15:0];
         sy0_ff    <= sel_stance[31:16];
         sz0_ff    <= sel_stance[47:32];
      end
   end

   // Stage 1: the second round of products. The angle is exact in Q.28 radians,
   // and the remaining swing time is in units of 2^-32 seconds.
   logic signed [ANG_W-1:0] ang_in;
   logic signed [PT_W-1:0]  ptime_in;
   logic signed [41:0]      offrx_in, offry_in;
   logic [DEN_W-1:0]        den_in;
   logic [31:0]             hraw_in;

   assign ang_in   = $signed({1'b0, stp_ff}) * yaw0_ff;
   assign ptime_in = $signed({1'b0, stp_ff}) * remain_ff;
   assign offrx_in = vptx_ff * $signed({1'b0, tick_ff});
   assign offry_in = vpty_ff * $signed({1'b0, tick_ff});
   assign den_in   = swing_ff * remain_ff[16:0];
   assign hraw_in  = ph_ff * lift_ff;

   logic signed [ANG_W-1:0] ang_ff;
   logic signed [PT_W-1:0]  ptime_ff;
   logic signed [41:0]      offrx_ff, offry_ff;
   logic [DEN_W-1:0]        den1_ff;
   logic [31:0]             hraw_ff;
   logic signed [15:0]      fx1_ff, fy1_ff, sx1_ff, sy1_ff, sz1_ff;

   always_ff @(posedge clock) begin
      if (f_rdy[1]) begin
         ang_ff   <= ang_in;
         ptime_ff <= ptime_in;
         offrx_ff <= offrx_in;
         offry_ff <= offry_in;
         den1_ff  <= den_in;
         hraw_ff  <= hraw_in;
         fx1_ff   <= fx0_ff;
         fy1_ff   <= fy0_ff;
         sx1_ff   <= sx0_ff;
         sy1_ff   <= sy0_ff;
         sz1_ff   <= sz0_ff;
      end
   end

   // Stage 2: round the velocity offset and the lift height, and flag a swing
   // with less than a microsecond left.
   logic signed [41:0] offrx_rnd, offry_rnd;
   logic [32:0]        hsum;
   logic [17:0]        hq;
   sfnp_rot_side_type  rside_in;

   assign offrx_rnd = offrx_ff + 42'sd32768;
   assign offry_rnd = offry_ff + 42'sd32768;
   assign hsum      = {1'b0, hraw_ff} + 33'd16384;
   assign hq        = hsum[32:15];

   always_comb begin
      rside_in.fx     = fx1_ff;
      rside_in.fy     = fy1_ff;
      rside_in.sx     = sx1_ff;
      rside_in.sy     = sy1_ff;
      rside_in.sz     = sz1_ff;
      rside_in.offx   = OFF_W'(offrx_rnd >>> 16);
      rside_in.offy   = OFF_W'(offry_rnd >>> 16);
      rside_in.notime = ptime_ff < MIN_TIME;
      rside_in.h      = (hq > 18'd32767) ? 16'd32767 : hq[15:0];
      rside_in.den    = den1_ff;
   end

   logic signed [ANG_W-1:0] ang2_ff;
   sfnp_rot_side_type       rside_ff;

   always_ff @(posedge clock) begin
      if (f_rdy[2]) begin
         ang2_ff  <= ang_ff;
         rside_ff <= rside_in;
      end
   end

   // ------------------------------------------------------------------
   // Sine and cosine of the yaw turn over one swing.
   // ------------------------------------------------------------------
   logic                    rot_out_valid;
   logic                    rot_out_stall;
   logic signed [VEC_W-1:0] rot_cos, rot_sin;
   sfnp_rot_side_type       rot_side;

   sfnp_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_v_ff[2]),
      .in_stall  (rot_in_stall),
      .in_ang    (ang2_ff),
      .in_side   (rside_ff),
      .out_valid (rot_out_valid),
      .out_stall (rot_out_stall),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin),
      .out_side  (rot_side)
   );

   // ------------------------------------------------------------------
   // Back stages: rotate the stance, form the touchdown point and set up
   // the step division.
   // ------------------------------------------------------------------
   logic [2:0] b_v_ff;
   logic [3:0] b_rdy;
   logic       div_in_stall;

   assign b_rdy[3]      = !div_in_stall;
   assign b_rdy[2]      = !b_v_ff[2] || b_rdy[3];
   assign b_rdy[1]      = !b_v_ff[1] || b_rdy[2];
   assign b_rdy[0]      = !b_v_ff[0] || b_rdy[1];
   assign rot_out_stall = !b_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= '0;
      end else begin
         if (b_rdy[0]) b_v_ff[0] <= rot_out_valid;
         if (b_rdy[1]) b_v_ff[1] <= b_v_ff[0];
         if (b_rdy[2]) b_v_ff[2] <= b_v_ff[1];
      end
   end

   // Stage 3: the four rotation products.
   logic signed [47:0] pcx_in, psy_in, psx_in, pcy_in;
   logic signed [47:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   sfnp_rot_side_type  bside3_ff;

   assign pcx_in = rot_cos * rot_side.sx;
   assign psy_in = rot_sin * rot_side.sy;
   assign psx_in = rot_sin * rot_side.sx;
   assign pcy_in = rot_cos * rot_side.sy;

   always_ff @(posedge clock) begin
      if (b_rdy[0]) begin
         pcx_ff    <= pcx_in;
         psy_ff    <= psy_in;
         psx_ff    <= psx_in;
         pcy_ff    <= pcy_in;
         bside3_ff <= rot_side;
      end
   end

   // Stage 4: rounded rotated stance plus the velocity offset gives the touchdown point.
   logic signed [48:0]     rotx_sum, roty_sum;
   logic signed [TD_W-1:0] tdx_in, tdy_in;
   logic signed [TD_W-1:0] tdx_ff, tdy_ff;
   sfnp_rot_side_type      bside4_ff;

   assign rotx_sum = 49'(pcx_ff) - 49'(psy_ff) + 49'sd536870912;
   assign roty_sum = 49'(psx_ff) + 49'(pcy_ff) + 49'sd536870912;
   assign tdx_in   = TD_W'(rotx_sum >>> 30) + TD_W'(bside3_ff.offx);
   assign tdy_in   = TD_W'(roty_sum >>> 30) + TD_W'(bside3_ff.offy);

   always_ff @(posedge clock) begin
      if (b_rdy[1]) begin
         tdx_ff    <= tdx_in;
         tdy_ff    <= tdy_in;
         bside4_ff <= bside3_ff;
      end
   end

   // Stage 5: distance left to the touchdown point, as a magnitude scaled by 2^16
   // with half the divisor added, so the divider rounds halves away from zero.
   logic signed [TD_W-1:0] nx, ny, magx, magy;
   logic [1:0][NUM_W-1:0]  num_in;
   sfnp_div_side_type      dside_in;

   assign nx        = tdx_ff - TD_W'(bside4_ff.fx);
   assign ny        = tdy_ff - TD_W'(bside4_ff.fy);
   assign magx      = (nx < 0) ? -nx : nx;
   assign magy      = (ny < 0) ? -ny : ny;
   assign num_in[0] = NUM_W'({magx[TD_W-2:0], 16'd0}) + NUM_W'(bside4_ff.den >> 1);
   assign num_in[1] = NUM_W'({magy[TD_W-2:0], 16'd0}) + NUM_W'(bside4_ff.den >> 1);

   always_comb begin
      dside_in.fx     = bside4_ff.fx;
      dside_in.fy     = bside4_ff.fy;
      dside_in.sz     = bside4_ff.sz;
      dside_in.tdx    = tdx_ff;
      dside_in.tdy    = tdy_ff;
      dside_in.notime = bside4_ff.notime;
      dside_in.h      = bside4_ff.h;
      dside_in.neg_x  = nx < 0;
      dside_in.neg_y  = ny < 0;
   end

   logic [1:0][NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]      den5_ff;
   sfnp_div_side_type     dside_ff;

   always_ff @(posedge clock) begin
      if (b_rdy[2]) begin
         num_ff   <= num_in;
         den5_ff  <= bside4_ff.den;
         dside_ff <= dside_in;
      end
   end

   // ------------------------------------------------------------------
   // Step division. When no swing time remains the divisor may be zero or
   // meaningless; that quotient is discarded in the output stage.
   // ------------------------------------------------------------------
   logic                  div_out_valid;
   logic                  div_out_stall;
   logic [1:0][QUO_W-1:0] div_quo;
   sfnp_div_side_type     div_side;

   sfnp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_v_ff[2]),
      .in_stall  (div_in_stall),
      .in_num    (num_ff),
      .in_den    (den5_ff),
      .in_side   (dside_ff),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // ------------------------------------------------------------------
   // Output register: either the saturated touchdown point with the stance
   // height, or the foot moved by one step with the lift profile height.
   // ------------------------------------------------------------------
   logic                   ov_ff;
   logic                   o_rdy;
   logic signed [QUO_W:0]  stepx, stepy;
   logic signed [TD_W-1:0] sumx, sumy;
   logic signed [15:0]     nxo_in, nyo_in, nzo_in;
   logic signed [15:0]     nxo_ff, nyo_ff, nzo_ff;

   assign o_rdy         = !ov_ff || !rsp_stall;
   assign div_out_stall = !o_rdy;

   assign stepx = div_side.neg_x ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
   assign stepy = div_side.neg_y ? -$signed({1'b0, div_quo[1]}) : $signed({1'b0, div_quo[1]});
   assign sumx  = TD_W'(div_side.fx) + TD_W'(stepx);
   assign sumy  = TD_W'(div_side.fy) + TD_W'(stepy);

   always_comb begin
      if (div_side.notime) begin
         nxo_in = sat16(div_side.tdx);
         nyo_in = sat16(div_side.tdy);
         nzo_in = div_side.sz;
      end else begin
         nxo_in = sat16(sumx);
         nyo_in = sat16(sumy);
         nzo_in = $signed(div_side.h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (o_rdy) begin
         ov_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy) begin
         nxo_ff <= nxo_in;
         nyo_ff <= nyo_in;
         nzo_ff <= nzo_in;
      end
   end

   assign rsp_valid  = ov_ff;
   assign rsp_next_x = nxo_ff;
   assign rsp_next_y = nyo_ff;
   assign rsp_next_z = nzo_ff;

`ifndef SYNTH
   a_no_stall_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while the result side is open");

   a_unit_vector: assert property (@(posedge clock) disable iff (reset)
      rot_out_valid |-> (rot_cos <= 32'sd1100000000 && rot_cos >= -32'sd1100000000 &&
                         rot_sin <= 32'sd1100000000 && rot_sin >= -32'sd1100000000))
      else $error("rotation vector out of range");

   a_result_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(div_out_valid))
      else $error("result beat without a divider beat");
`endif

endmodule

// ----- rtl/core/sfnp_cordic.sv -----
// Angle reduction modulo two pi, quadrant fold and pipelined rotation-mode CORDIC.
// Depends on sfnp_pkg; carries the placement sideband alongside the angle.
module sfnp_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic signed [sfnp_pkg::ANG_W-1:0]     in_ang,
   input  sfnp_pkg::sfnp_rot_side_type           in_side,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic signed [sfnp_pkg::VEC_W-1:0]     out_cos,
   output logic signed [sfnp_pkg::VEC_W-1:0]     out_sin,
   output sfnp_pkg::sfnp_rot_side_type           out_side
);
   import sfnp_pkg::*;

   localparam int FOLD_K = RED_STEPS;
   localparam int ROT_K0 = RED_STEPS + 1;
   localparam int NS     = RED_STEPS + CORDIC_STEPS + 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   rdy;

   sfnp_rot_side_type side_ff  [NS];
   sfnp_rot_side_type side_src [NS];

   logic [MAG_W-1:0] mag_ff  [RED_STEPS];
   logic [MAG_W-1:0] mag_src [RED_STEPS];
   logic             neg_ff  [RED_STEPS];
   logic             neg_src [RED_STEPS];

   logic signed [PH_W-1:0] fold_r_ff;
   logic                   fold_flip_ff;
   logic signed [PH_W-1:0] fold_r_in;
   logic                   fold_flip_in;

   logic signed [VEC_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [PH_W-1:0]  z_ff [CORDIC_STEPS];
   logic                    f_ff [CORDIC_STEPS];

   logic signed [VEC_W-1:0] cos_ff;
   logic signed [VEC_W-1:0] sin_ff;

   assign rdy[NS]  = !out_stall;
   assign in_stall = !rdy[0];
   assign v_in     = {v_ff[NS-2:0], in_valid};

   genvar k;
   for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int j = 0; j < NS; j++) begin
            if (rdy[j]) begin
               v_ff[j] <= v_in[j];
            end
         end
      end
   end

   assign side_src[0] = in_side;
   for (k = 0; k < NS; k++) begin : g_side
      if (k > 0) begin : g_link
         assign side_src[k] = side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            side_ff[k] <= side_src[k];
         end
      end
   end

   // Restoring reduction of the magnitude, one power-of-two multiple of two pi per stage, largest first.
   assign mag_src[0] = in_ang[ANG_W-1] ? MAG_W'(-in_ang) : MAG_W'(in_ang);
   assign neg_src[0] = in_ang[ANG_W-1];
   for (k = 0; k < RED_STEPS; k++) begin : g_red
      localparam logic [MAG_W-1:0] SUB = TWO_PI_MAG << (RED_STEPS - 1 - k);
      logic [MAG_W-1:0] mag_in;
      if (k > 0) begin : g_link
         assign mag_src[k] = mag_ff[k-1];
         assign neg_src[k] = neg_ff[k-1];
      end
      assign mag_in = (mag_src[k] >= SUB) ? mag_src[k] - SUB : mag_src[k];
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            mag_ff[k] <= mag_in;
            neg_ff[k] <= neg_src[k];
         end
      end
   end

   // Restore the sign, wrap into [-pi, pi] and fold into [-pi/2, pi/2].
   always_comb begin
      logic signed [PH_W-1:0] r0;
      logic signed [PH_W-1:0] r1;
      r0 = $signed(PH_W'(mag_ff[RED_STEPS-1]));
      if (neg_ff[RED_STEPS-1]) begin
         r0 = -r0;
      end
      if (r0 > ANG_PI) begin
         r1 = r0 - ANG_TWO_PI;
      end else if (r0 < -ANG_PI) begin
         r1 = r0 + ANG_TWO_PI;
      end else begin
         r1 = r0;
      end
      fold_flip_in = 1'b0;
      fold_r_in    = r1;
      if (r1 > ANG_HALF_PI) begin
         fold_r_in    = r1 - ANG_PI;
         fold_flip_in = 1'b1;
      end else if (r1 < -ANG_HALF_PI) begin
         fold_r_in    = r1 + ANG_PI;
         fold_flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[FOLD_K]) begin
         fold_r_ff    <= fold_r_in;
         fold_flip_ff <= fold_flip_in;
      end
   end

   for (k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      localparam logic signed [PH_W-1:0] ATAN = atan_q28(k);
      logic signed [VEC_W-1:0] x_src, y_src, x_in, y_in;
      logic signed [PH_W-1:0]  z_src, z_in;
      logic                    f_src;
      if (k == 0) begin : g_first
         assign x_src = CORDIC_GAIN;
         assign y_src = '0;
         assign z_src = fold_r_ff;
         assign f_src = fold_flip_ff;
      end else begin : g_next
         assign x_src = x_ff[k-1];
         assign y_src = y_ff[k-1];
         assign z_src = z_ff[k-1];
         assign f_src = f_ff[k-1];
      end
      always_comb begin
         if (z_src >= 0) begin
            x_in = x_src - (y_src >>> k);
            y_in = y_src + (x_src >>> k);
            z_in = z_src - ATAN;
         end else begin
            x_in = x_src + (y_src >>> k);
            y_in = y_src - (x_src >>> k);
            z_in = z_src + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[ROT_K0 + k]) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
            f_ff[k] <= f_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         cos_ff <= f_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];
         sin_ff <= f_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = side_ff[NS-1];

`ifndef SYNTH
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[FOLD_K] |-> (fold_r_ff <= ANG_HALF_PI && fold_r_ff >= -ANG_HALF_PI))
      else $error("folded angle outside half pi");
`endif

endmodule

// ----- rtl/core/sfnp_div.sv -----
// Two-lane pipelined restoring divider with a saturating quotient, one bit per stage.
// Depends on sfnp_pkg; both lanes share the divisor and carry the output sideband.
module sfnp_div (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_stall,
   input  logic [1:0][sfnp_pkg::NUM_W-1:0]             in_num,
   input  logic [sfnp_pkg::DEN_W-1:0]                  in_den,
   input  sfnp_pkg::sfnp_div_side_type                 in_side,
   output logic                                        out_valid,
   input  logic                                        out_stall,
   output logic [1:0][sfnp_pkg::QUO_W-1:0]             out_quo,
   output sfnp_pkg::sfnp_div_side_type                 out_side
);
   import sfnp_pkg::*;

   localparam int NS = QUO_W + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   rdy;

   sfnp_div_side_type side_ff [NS];
   logic [DEN_W-1:0]  den_ff  [NS];
   logic [NUM_W-1:0]  rem_ff  [NS][2];
   logic [QUO_W-1:0]  quo_ff  [NS][2];
   logic              ovf_ff  [NS][2];

   assign rdy[NS]  = !out_stall;
   assign in_stall = !rdy[0];
   assign v_in     = {v_ff[NS-2:0], in_valid};

   genvar k, l;
   for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int j = 0; j < NS; j++) begin
            if (rdy[j]) begin
               v_ff[j] <= v_in[j];
            end
         end
      end
   end

   // First stage: a quotient that needs more than QUO_W bits saturates.
   for (l = 0; l < 2; l++) begin : g_lane0
      logic ovf_in;
      assign ovf_in = in_num[l] >= {in_den, QUO_W'(0)};
      always_ff @(posedge clock) begin
         if (rdy[0]) begin
            rem_ff[0][l] <= in_num[l];
            ovf_ff[0][l] <= ovf_in;
            quo_ff[0][l] <= ovf_in ? '1 : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (k = 1; k < NS; k++) begin : g_stage
      localparam int BIT = QUO_W - k;
      logic [NUM_W-1:0] dsh;
      assign dsh = NUM_W'(den_ff[k-1]) << BIT;
      for (l = 0; l < 2; l++) begin : g_lane
         logic             take;
         logic [NUM_W-1:0] rem_in;
         logic [QUO_W-1:0] quo_in;
         assign take   = !ovf_ff[k-1][l] && (rem_ff[k-1][l] >= dsh);
         assign rem_in = take ? rem_ff[k-1][l] - dsh : rem_ff[k-1][l];
         assign quo_in = take ? (quo_ff[k-1][l] | (QUO_W'(1) << BIT)) : quo_ff[k-1][l];
         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               rem_ff[k][l] <= rem_in;
               quo_ff[k][l] <= quo_in;
               ovf_ff[k][l] <= ovf_ff[k-1][l];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid  = v_ff[NS-1];
   assign out_quo[0] = quo_ff[NS-1][0];
   assign out_quo[1] = quo_ff[NS-1][1];
   assign out_side   = side_ff[NS-1];

`ifndef SYNTH
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-1] && !ovf_ff[NS-1][0]) |-> (rem_ff[NS-1][0] < NUM_W'(den_ff[NS-1])))
      else $error("divider remainder not below divisor");
`endif

endmodule

// ----- test/sfnp_checker.sv -----
`timescale 1ns / 100ps
// Checker for the swing foot next position core: it follows register writes, predicts each
// result beat from the accepted input beats and compares. It depends on sfnp_pkg only.
module sfnp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [16:0]        req_swing_progress,
   input  logic [1:0]         req_leg_number,
   input  logic signed [15:0] req_foot_x,
   input  logic signed [15:0] req_foot_y,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_yaw_rate,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_next_x,
   input  logic signed [15:0] rsp_next_y,
   input  logic signed [15:0] rsp_next_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   input  logic               pready,
   output int                 errors,
   output int                 pending
);
   import sfnp_pkg::*;

   localparam int LEGS  = 4;
   localparam int STEPS = 16;
   localparam longint TWO_PI_Q28  = 64'sd1686629713;
   localparam longint PI_Q28      = 64'sd843314857;
   localparam longint HALF_PI_Q28 = 64'sd421657428;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint MIN_TIME_Q32 = 64'sd4295;
   localparam longint ATAN_TABLE [16] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
      1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } foot_target_type;

   // Shadow copy of the configuration registers.
   logic [9:0]  swing_len;
   logic [9:0]  phase_ticks;
   logic [15:0] tick_period;
   logic [14:0] lift_height;
   logic [47:0] stance [LEGS];

   foot_target_type targets_due[$];

   function automatic longint round_shr(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Rounds to nearest with halves away from zero.
   function automatic longint div_nearest(input longint n, input longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic logic signed [15:0] clamp_q312(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Cosine and sine in Q.30 of a Q.28 angle, by range reduction and CORDIC rotation.
   function automatic void rotate_unit(input longint ang, output longint c, output longint s);
      longint r, x, y, nx;
      bit flip;
      r = ang % TWO_PI_Q28;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      if (r > PI_Q28) r -= TWO_PI_Q28;
      if (r < -PI_Q28) r += TWO_PI_Q28;
      if (r > HALF_PI_Q28) begin
         r -= PI_Q28;
         flip = 1;
      end else if (r < -HALF_PI_Q28) begin
         r += PI_Q28;
         flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (r >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            r -= ATAN_TABLE[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            r += ATAN_TABLE[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic foot_target_type predict_foot(
      input logic [16:0] prog_in, input logic [1:0] leg,
      input logic signed [15:0] fx_in, input logic signed [15:0] fy_in,
      input logic signed [15:0] vx_in, input logic signed [15:0] vy_in,
      input logic signed [15:0] yaw_in);
      foot_target_type t;
      logic [47:0] sr;
      longint prog, fx, fy, st, pt, tp, lift, sx, sy, sz, c, s, tdx, tdy, remain, den, h;
      prog = prog_in;
      fx = fx_in;
      fy = fy_in;
      st = swing_len;
      pt = phase_ticks;
      tp = tick_period;
      lift = lift_height;
      sr = (leg < LEGS) ? stance[leg] : '0;
      sx = $signed(sr[15:0]);
      sy = $signed(sr[31:16]);
      sz = $signed(sr[47:32]);
      rotate_unit(st * tp * longint'(yaw_in), c, s);
      tdx = round_shr(c * sx - s * sy, 30) + round_shr(longint'(vx_in) * pt * tp, 16);
      tdy = round_shr(s * sx + c * sy, 30) + round_shr(longint'(vy_in) * pt * tp, 16);
      remain = 65536 - prog;
      if (tp * st * remain < MIN_TIME_Q32) begin
         // Swing is over: land on the touchdown point at stance height.
         t.nx = clamp_q312(tdx);
         t.ny = clamp_q312(tdy);
         t.nz = clamp_q312(sz);
      end else begin
         h = (prog < 32768) ? round_shr(prog * lift, 15) : round_shr(remain * lift, 15);
         den = st * remain;
         t.nx = clamp_q312(fx + div_nearest((tdx - fx) * 65536, den));
         t.ny = clamp_q312(fy + div_nearest((tdy - fy) * 65536, den));
         t.nz = clamp_q312(h);
      end
      return t;
   endfunction

   always @(posedge clock) begin
      foot_target_type want;
      int bad;
      if (reset) begin
         swing_len   <= 10'd10;
         phase_ticks <= 10'd20;
         tick_period <= 16'd655;
         lift_height <= 15'd410;
         for (int i = 0; i < LEGS; i++) stance[i] <= '0;
         targets_due.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         bad = 0;
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_SWING_TICKS: swing_len   <= pwdata[9:0];
               REG_PHASE_TICKS: phase_ticks <= pwdata[9:0];
               REG_TICK_PERIOD: tick_period <= pwdata[15:0];
               REG_LIFT_HEIGHT: lift_height <= pwdata[14:0];
               REG_STANCE_LEG0: stance[0] <= pwdata[47:0];
               REG_STANCE_LEG1: stance[1] <= pwdata[47:0];
               REG_STANCE_LEG2: stance[2] <= pwdata[47:0];
               REG_STANCE_LEG3: stance[3] <= pwdata[47:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            targets_due.push_back(predict_foot(req_swing_progress, req_leg_number,
               req_foot_x, req_foot_y, req_vel_x, req_vel_y, req_yaw_rate));
         end
         if (rsp_valid && !rsp_stall) begin
            if (targets_due.size() == 0) begin
               $error("result beat with no input beat waiting");
               bad = bad + 1;
            end else begin
               want = targets_due.pop_front();
               if (rsp_next_x !== want.nx) begin
                  $error("next_x: expected %0d, got %0d", want.nx, rsp_next_x);
                  bad = bad + 1;
               end
               if (rsp_next_y !== want.ny) begin
                  $error("next_y: expected %0d, got %0d", want.ny, rsp_next_y);
                  bad = bad + 1;
               end
               if (rsp_next_z !== want.nz) begin
                  $error("next_z: expected %0d, got %0d", want.nz, rsp_next_z);
                  bad = bad + 1;
               end
            end
         end
         errors  <= errors + bad;
         pending <= targets_due.size();
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the swing foot next position testbench: clock, reset, register writes and beats.
// It depends on sfnp_pkg, the core and sfnp_checker, which does all result checking.
module tb_top;
   import sfnp_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [16:0]        req_swing_progress;
   logic [1:0]         req_leg_number;
   logic signed [15:0] req_foot_x;
   logic signed [15:0] req_foot_y;
   logic signed [15:0] req_vel_x;
   logic signed [15:0] req_vel_y;
   logic signed [15:0] req_yaw_rate;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_next_x;
   logic signed [15:0] rsp_next_y;
   logic signed [15:0] rsp_next_z;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [5:0]         paddr;
   logic [63:0]        pwdata;
   logic [63:0]        prdata;
   logic               pready;
   int                 errors;
   int                 pending;

   // When set, neither side inserts gaps or stalls, so the pipeline runs back to back.
   bit                 steady_flow;

   // The drain pause after the last result adds margin.
   localparam int DRAIN_CYCLES = 80;

   swing_foot_next_position_core u_dut (.*);

   sfnp_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A generous bound: every beat waiting out both the longest gap and the longest stall.
   initial begin
      #(12 * 1000000);
      $display("TB_ERROR");
      $finish;
   end

   // Result side: for each result beat the receiver stalls a random number of cycles first.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 12);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // A register write: a setup phase, an access phase, then an idle phase.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_gait(input logic [9:0] swing, input logic [9:0] phase,
                             input logic [15:0] period, input logic [14:0] lift);
      write_reg(REG_SWING_TICKS, 64'(swing));
      write_reg(REG_PHASE_TICKS, 64'(phase));
      write_reg(REG_TICK_PERIOD, 64'(period));
      write_reg(REG_LIFT_HEIGHT, 64'(lift));
   endtask

   // Stance registers hold x in bits 15:0, y in 31:16 and z in 47:32.
   function automatic logic [63:0] random_stance(input bit wide);
      logic [15:0] x, y, z;
      if (wide) begin
         x = 16'($urandom);
         y = 16'($urandom);
         z = 16'($urandom);
      end else begin
         x = 16'($signed($urandom_range(0, 4096)) - 2048);
         y = 16'($signed($urandom_range(0, 4096)) - 2048);
         z = 16'($signed($urandom_range(0, 2048)) - 1536);
      end
      return {16'h0, z, y, x};
   endfunction

   task automatic write_stances(input bit wide);
      write_reg(REG_STANCE_LEG0, random_stance(wide));
      write_reg(REG_STANCE_LEG1, random_stance(wide));
      write_reg(REG_STANCE_LEG2, random_stance(wide));
      write_reg(REG_STANCE_LEG3, random_stance(wide));
   endtask

   // Registers change only with the pipeline empty, so wait for every result to drain.
   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sends one input beat after a random gap; valid stays high when there is no gap.
   task automatic send_update(input logic [16:0] prog, input logic [1:0] leg,
                              input logic signed [15:0] fx, input logic signed [15:0] fy,
                              input logic signed [15:0] vx, input logic signed [15:0] vy,
                              input logic signed [15:0] yaw);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_swing_progress <= prog;
      req_leg_number     <= leg;
      req_foot_x         <= fx;
      req_foot_y         <= fy;
      req_vel_x          <= vx;
      req_vel_y          <= vy;
      req_yaw_rate       <= yaw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_q312(input bit wide);
      if (wide) return 16'($urandom);
      return 16'($signed($urandom_range(0, 16384)) - 8192);
   endfunction

   // Most beats are mid-swing; some sit at the very end and some lie past completion.
   task automatic send_random_update;
      logic [16:0] prog;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 8) prog = 17'($urandom_range(0, 65536));
      else if (pick == 8) prog = 17'($urandom_range(65500, 65536));
      else prog = 17'($urandom_range(65537, 131071));
      send_update(prog, 2'($urandom), random_q312(1'($urandom_range(0, 1))),
                  random_q312(1'($urandom_range(0, 1))), random_q312(1'($urandom_range(0, 1))),
                  random_q312(1'($urandom_range(0, 1))), random_q312($urandom_range(0, 3) == 0));
   endtask

   task automatic send_random_batch(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         send_random_update();
      end
      steady_flow = 1'b0;
      req_valid <= 1'b0;
   endtask

   initial begin
      req_valid          = 1'b0;
      req_swing_progress = '0;
      req_leg_number     = '0;
      req_foot_x         = '0;
      req_foot_y         = '0;
      req_vel_x          = '0;
      req_vel_y          = '0;
      req_yaw_rate       = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      steady_flow        = 1'b0;
      reset              = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults with all-zero stances.
      send_random_batch(40);
      drain();

      write_gait(10'd12, 10'd24, 16'd655, 15'd410);
      write_stances(1'b0);

      // Directed beats: progress at start, just below and at half swing, near the end,
      // exactly complete and beyond complete; every leg; field extremes.
      send_update(17'd0, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_update(17'd32767, 2'd1, 16'sd100, -16'sd100, 16'sd4096, -16'sd4096, 16'sd2048);
      send_update(17'd32768, 2'd2, -16'sd300, 16'sd300, -16'sd4096, 16'sd4096, -16'sd2048);
      send_update(17'd65535, 2'd3, 16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 16'sd12868);
      send_update(17'd65536, 2'd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0);
      send_update(17'd65537, 2'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0);
      send_update(17'd131071, 2'd2, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_update(17'd1, 2'd3, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_update(17'd65530, 2'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_update(17'd16384, 2'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_update(17'd49152, 2'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd6434);
      send_update(17'd65000, 2'd3, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
      req_valid <= 1'b0;
      drain();

      // Smallest gait with no lift: the remaining time test and the step rounding matter.
      write_gait(10'd1, 10'd1, 16'd1, 15'd0);
      write_stances(1'b1);
      send_random_batch(250);
      drain();

      // Largest gait and lift: big angles and saturated outputs.
      write_gait(10'd1023, 10'd1023, 16'd65535, 15'd32767);
      write_stances(1'b1);
      send_random_batch(250);
      drain();

      // Zero swing length and time step: every beat lands on the touchdown point.
      write_gait(10'd0, 10'd0, 16'd0, 15'd20000);
      write_stances(1'b0);
      send_random_batch(150);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_gait(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                    16'($urandom_range(1, 65535)), 15'($urandom_range(0, 32767)));
         write_stances(p[0]);
         send_random_batch(230);
         drain();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
